// File: rtl/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg: shared types and constants of the polar Gaussian sampler
// Operation codes and handshake structs for the iterative divide/sqrt unit,
// fixed-point constants and field widths.
// ----------------------------------------------------------------------------
package gps_pkg;

    // field widths
    localparam int FIELD_W = 16;
    localparam int MUL_W = 33;
    localparam int PROD_W = 2 * MUL_W;

    // default number of fraction bits of the uniforms
    localparam int UNIFORM_FRAC_BITS_DEF = 15;

    // log2 fraction precision and 2*ln(2) in Q30
    localparam int LOG_FRAC_BITS = 24;
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

    // deviate saturation limit (Q4.12)
    localparam logic [15:0] DEV_MAX = 16'd32767;

    // iteration counts of the shared divide/sqrt unit
    localparam logic [5:0] DIV_STEPS = 6'd33;
    localparam logic [5:0] SQRT_STEPS = 6'd16;

    typedef enum logic
    {
        ITER_DIV  = 1'b0,
        ITER_SQRT = 1'b1
    } iter_op_t;

    typedef struct packed
    {
        logic     start;
        iter_op_t op;
    } iter_req_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } iter_stat_t;

endpackage

// File: rtl/gps_mul.sv
// ----------------------------------------------------------------------------
// gps_mul: shared registered multiplier
// Unsigned 33x33 product, registered; the result is valid in the cycle after
// the operands are presented.
// ----------------------------------------------------------------------------
module gps_mul
(
    input  logic                           clk,
    input  logic [gps_pkg::MUL_W-1:0]      op_a,
    input  logic [gps_pkg::MUL_W-1:0]      op_b,
    output logic [gps_pkg::PROD_W-1:0]     prod
);

    logic [gps_pkg::PROD_W-1:0] prod_reg;
    logic [gps_pkg::PROD_W-1:0] prod_next;

    // product
    always_comb
    begin
        prod_next = {{gps_pkg::MUL_W{1'b0}}, op_a} * {{gps_pkg::MUL_W{1'b0}}, op_b};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/gps_iter.sv
// ----------------------------------------------------------------------------
// gps_iter: shared iterative divide / square-root unit
// Restoring division (one quotient bit a cycle, 33 bits) or digit-by-digit
// integer square root (one root bit a cycle, 16 bits) on one subtractor.
// ----------------------------------------------------------------------------
module gps_iter
(
    input  logic                clk,
    input  logic                rst_n,
    input  gps_pkg::iter_req_t  req,
    input  logic [31:0]         num,
    input  logic [31:0]         den,
    output gps_pkg::iter_stat_t stat,
    output logic [32:0]         result
);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [5:0]        cnt_reg;
    logic [5:0]        cnt_next;
    gps_pkg::iter_op_t op_reg;
    gps_pkg::iter_op_t op_next;
    logic [31:0]       rem_reg;
    logic [31:0]       rem_next;
    logic [31:0]       sh_reg;
    logic [31:0]       sh_next;
    logic [32:0]       quot_reg;
    logic [32:0]       quot_next;
    logic [31:0]       den_reg;
    logic [31:0]       den_next;
    logic [33:0]       rem_sh;
    logic [33:0]       trial;
    logic [33:0]       diff;
    logic              ge;

    // one step of the shared subtractor
    always_comb
    begin
        if (op_reg == gps_pkg::ITER_DIV)
        begin
            rem_sh = {1'b0, rem_reg, sh_reg[31]};
            trial  = {2'b00, den_reg};
        end
        else
        begin
            rem_sh = {rem_reg, sh_reg[31:30]};
            trial  = {quot_reg[31:0], 2'b01};
        end
        ge   = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    // sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            den_next  = den;
            quot_next = '0;
            if (req.op == gps_pkg::ITER_DIV)
            begin
                rem_next = {1'b0, num[31:1]};
                sh_next  = {num[0], 31'b0};
                cnt_next = gps_pkg::DIV_STEPS;
            end
            else
            begin
                rem_next = '0;
                sh_next  = num;
                cnt_next = gps_pkg::SQRT_STEPS;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[31:0] : rem_sh[31:0];
            quot_next = {quot_reg[31:0], ge};
            sh_next   = (op_reg == gps_pkg::ITER_DIV) ? {sh_reg[30:0], 1'b0}
                                                      : {sh_reg[29:0], 2'b00};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= gps_pkg::ITER_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = quot_reg;

endmodule

// File: rtl/gaussian_polar_sampler.sv
// ----------------------------------------------------------------------------
// gaussian_polar_sampler: Marsaglia polar Gaussian sampler, fixed point
// Sequencer around a shared multiplier and a shared divide/sqrt unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries uniform_a, uniform_b, mean_value
//   and spread. in_stall is high while an item is being worked on; one item is
//   processed at a time.
//   Output channel (out_valid / out_stall) carries sample. A rejected pair
//   (s zero or above one) gives no item; in_stall stays high through ST_SQA,
//   ST_SQB, ST_SUM and ST_NORM, and the next item is taken back in ST_IDLE.
//   An item served from the stored spare deviate goes from ST_IDLE through
//   ST_SCALE to ST_FIN, where its sample is loaded. A fresh pair goes through
//   the squares, sum and range check, 24 log2 squarings on the shared
//   multiplier and w, then per deviate the division, the q product and the
//   square root, and last the scaling and the load. The next item is taken
//   once the sequencer is back in ST_IDLE. Every second item uses the spare.
//   The result sits in an output register; the next input item is taken
//   while it waits. When the receiver stalls, a finished result is held
//   back until the output register frees up, and the input stays stalled.
//   Reset clears the spare deviate and all control state; no item is
//   pending afterwards.
// ----------------------------------------------------------------------------
module gaussian_polar_sampler
#(
    parameter int UNIFORM_FRAC_BITS = gps_pkg::UNIFORM_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] uniform_a,
    input  logic [15:0] uniform_b,
    input  logic [15:0] mean_value,
    input  logic [15:0] spread,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] sample
);

    localparam logic [63:0] S_ONE = 64'd1 << (2 * UNIFORM_FRAC_BITS);
    localparam logic [5:0]  TWO_F = 6'(2 * UNIFORM_FRAC_BITS);

    typedef enum logic [16:0]
    {
        ST_IDLE  = 17'b00000000000000001,
        ST_SQA   = 17'b00000000000000010,
        ST_SQB   = 17'b00000000000000100,
        ST_SUM   = 17'b00000000000001000,
        ST_NORM  = 17'b00000000000010000,
        ST_LOGM  = 17'b00000000000100000,
        ST_LOGC  = 17'b00000000001000000,
        ST_WMUL  = 17'b00000000010000000,
        ST_WGET  = 17'b00000000100000000,
        ST_DIVS  = 17'b00000001000000000,
        ST_DIVW  = 17'b00000010000000000,
        ST_QMUL  = 17'b00000100000000000,
        ST_QGET  = 17'b00001000000000000,
        ST_SQRTS = 17'b00010000000000000,
        ST_SQRTW = 17'b00100000000000000,
        ST_SCALE = 17'b01000000000000000,
        ST_FIN   = 17'b10000000000000000
    } state_t;

    state_t      state_reg, state_next;

    // latched item
    logic [15:0] ua_reg, ua_next;
    logic [15:0] ub_reg, ub_next;
    logic [15:0] mean_reg, mean_next;
    logic [15:0] spread_reg, spread_next;

    // working registers
    logic [30:0] asq_reg, asq_next;
    logic [30:0] bsq_reg, bsq_next;
    logic [31:0] s_reg, s_next;
    logic [4:0]  p_reg, p_next;
    logic [30:0] m_reg, m_next;
    logic [23:0] frac_reg, frac_next;
    logic [4:0]  lcnt_reg, lcnt_next;
    logic [30:0] w_reg, w_next;
    logic [32:0] r_reg, r_next;
    logic        sel_reg, sel_next;
    logic [15:0] dev_a_reg, dev_a_next;
    logic [15:0] dev_b_reg, dev_b_next;
    logic [15:0] dev_src_reg, dev_src_next;
    logic        use_spare_reg, use_spare_next;

    // architectural state and output register
    logic [15:0] spare_dev_reg, spare_dev_next;
    logic        spare_valid_reg, spare_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] sample_reg, sample_next;

    // shared units
    logic [gps_pkg::MUL_W-1:0]  mul_a;
    logic [gps_pkg::MUL_W-1:0]  mul_b;
    logic [gps_pkg::PROD_W-1:0] mul_prod;
    gps_pkg::iter_req_t         iter_req;
    gps_pkg::iter_stat_t        iter_stat;
    logic [31:0]                iter_num;
    logic [32:0]                iter_res;

    // helpers
    logic        in_accept;
    logic        out_load;
    logic [15:0] mag_a;
    logic [15:0] mag_b;
    logic [15:0] mag_dev;
    logic [4:0]  msb_pos;
    logic [31:0] s_norm;
    logic [29:0] lg;
    logic [31:0] log_t;
    logic [15:0] root_sat;
    logic [15:0] dev_new;
    logic [32:0] scaled;
    logic [21:0] y;
    logic        x_neg;

    // magnitudes of the signed inputs
    assign mag_a   = ua_reg[15] ? 16'(-ua_reg) : ua_reg;
    assign mag_b   = ub_reg[15] ? 16'(-ub_reg) : ub_reg;
    assign mag_dev = dev_src_reg[15] ? 16'(-dev_src_reg) : dev_src_reg;

    // leading-one position of s
    always_comb
    begin
        msb_pos = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (s_reg[i])
            begin
                msb_pos = 5'(i);
            end
        end
    end

    assign s_norm = s_reg << (5'd31 - msb_pos);

    // -log2(s) in Q24
    assign lg    = {TWO_F - {1'b0, p_reg}, 24'b0} - {6'b0, frac_reg};
    assign log_t = mul_prod[61:30];

    // saturated deviate with the sign of the selected uniform
    assign x_neg    = sel_reg ? ub_reg[15] : ua_reg[15];
    assign root_sat = (iter_res[15:0] > gps_pkg::DEV_MAX) ? gps_pkg::DEV_MAX
                                                         : iter_res[15:0];
    assign dev_new  = x_neg ? 16'(-root_sat) : root_sat;

    // signed scale, floor shift and offset; saturation follows in ST_FIN
    assign scaled = dev_src_reg[15] ? 33'(-mul_prod[32:0]) : mul_prod[32:0];
    assign y      = {scaled[32], scaled[32:12]} + {{6{mean_reg[15]}}, mean_reg};

    // shared multiplier operand select; in ST_QGET and ST_FIN the operands stay up while the product is read
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (1'b1)
            state_reg[5'd1]:
            begin
                mul_a = {17'b0, mag_a};
                mul_b = {17'b0, mag_a};
            end
            state_reg[5'd2]:
            begin
                mul_a = {17'b0, mag_b};
                mul_b = {17'b0, mag_b};
            end
            state_reg[5'd5]:
            begin
                mul_a = {2'b0, m_reg};
                mul_b = {2'b0, m_reg};
            end
            state_reg[5'd7]:
            begin
                mul_a = {3'b0, lg};
                mul_b = {2'b0, gps_pkg::TWO_LN2_Q30};
            end
            state_reg[5'd11], state_reg[5'd12]:
            begin
                mul_a = {2'b0, w_reg};
                mul_b = r_reg;
            end
            state_reg[5'd15], state_reg[5'd16]:
            begin
                mul_a = {17'b0, mag_dev};
                mul_b = {17'b0, spread_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gps_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // divide/sqrt requests
    assign iter_req.start = (state_reg == ST_DIVS) || (state_reg == ST_SQRTS);
    assign iter_req.op    = (state_reg == ST_SQRTS) ? gps_pkg::ITER_SQRT : gps_pkg::ITER_DIV;
    assign iter_num       = (state_reg == ST_SQRTS) ? mul_prod[63:32]
                          : (sel_reg ? {1'b0, bsq_reg} : {1'b0, asq_reg});

    gps_iter u_iter
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (iter_req),
        .num    (iter_num),
        .den    (s_reg),
        .stat   (iter_stat),
        .result (iter_res)
    );

    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        ua_next          = ua_reg;
        ub_next          = ub_reg;
        mean_next        = mean_reg;
        spread_next      = spread_reg;
        asq_next         = asq_reg;
        bsq_next         = bsq_reg;
        s_next           = s_reg;
        p_next           = p_reg;
        m_next           = m_reg;
        frac_next        = frac_reg;
        lcnt_next        = lcnt_reg;
        w_next           = w_reg;
        r_next           = r_reg;
        sel_next         = sel_reg;
        dev_a_next       = dev_a_reg;
        dev_b_next       = dev_b_reg;
        dev_src_next     = dev_src_reg;
        use_spare_next   = use_spare_reg;
        spare_dev_next   = spare_dev_reg;
        spare_valid_next = spare_valid_reg;
        out_valid_next   = out_valid_reg && out_stall;
        sample_next      = sample_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    ua_next        = uniform_a;
                    ub_next        = uniform_b;
                    mean_next      = mean_value;
                    spread_next    = spread;
                    use_spare_next = spare_valid_reg;
                    dev_src_next   = spare_dev_reg;
                    state_next     = spare_valid_reg ? ST_SCALE : ST_SQA;
                end
            end
            ST_SQA:
            begin
                state_next = ST_SQB;
            end
            ST_SQB:
            begin
                asq_next   = mul_prod[30:0];
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                bsq_next   = mul_prod[30:0];
                s_next     = {1'b0, asq_reg} + {1'b0, mul_prod[30:0]};
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if ((s_reg == 32'd0) || ({32'b0, s_reg} > S_ONE))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    p_next     = msb_pos;
                    m_next     = s_norm[31:1];
                    frac_next  = '0;
                    lcnt_next  = '0;
                    state_next = ST_LOGM;
                end
            end
            ST_LOGM:
            begin
                state_next = ST_LOGC;
            end
            ST_LOGC:
            begin
                m_next = log_t[31] ? log_t[31:1] : log_t[30:0];
                if (log_t[31])
                begin
                    frac_next = frac_reg | (24'd1 << (5'd23 - lcnt_reg));
                end
                lcnt_next  = lcnt_reg + 5'd1;
                state_next = (lcnt_reg == 5'(gps_pkg::LOG_FRAC_BITS - 1)) ? ST_WMUL
                                                                          : ST_LOGM;
            end
            ST_WMUL:
            begin
                state_next = ST_WGET;
            end
            ST_WGET:
            begin
                w_next     = mul_prod[60:30];
                sel_next   = 1'b0;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (iter_stat.done)
                begin
                    r_next     = iter_res;
                    state_next = ST_QMUL;
                end
            end
            ST_QMUL:
            begin
                state_next = ST_QGET;
            end
            ST_QGET:
            begin
                state_next = ST_SQRTS;
            end
            ST_SQRTS:
            begin
                state_next = ST_SQRTW;
            end
            ST_SQRTW:
            begin
                if (iter_stat.done)
                begin
                    if (!sel_reg)
                    begin
                        dev_a_next = dev_new;
                        sel_next   = 1'b1;
                        state_next = ST_DIVS;
                    end
                    else
                    begin
                        dev_b_next   = dev_new;
                        dev_src_next = dev_a_reg;
                        state_next   = ST_SCALE;
                    end
                end
            end
            ST_SCALE:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if ($signed(y) > 22'sd32767)
                    begin
                        sample_next = 16'h7FFF;
                    end
                    else if ($signed(y) < -22'sd32768)
                    begin
                        sample_next = 16'h8000;
                    end
                    else
                    begin
                        sample_next = y[15:0];
                    end
                    if (use_spare_reg)
                    begin
                        spare_valid_next = 1'b0;
                    end
                    else
                    begin
                        spare_dev_next   = dev_b_reg;
                        spare_valid_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            spare_dev_reg   <= '0;
            spare_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            spare_dev_reg   <= spare_dev_next;
            spare_valid_reg <= spare_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers; the product of ST_SCALE is held until ST_FIN loads
    always_ff @(posedge clk)
    begin
        ua_reg        <= ua_next;
        ub_reg        <= ub_next;
        mean_reg      <= mean_next;
        spread_reg    <= spread_next;
        asq_reg       <= asq_next;
        bsq_reg       <= bsq_next;
        s_reg         <= s_next;
        p_reg         <= p_next;
        m_reg         <= m_next;
        frac_reg      <= frac_next;
        lcnt_reg      <= lcnt_next;
        w_reg         <= w_next;
        r_reg         <= r_next;
        sel_reg       <= sel_next;
        dev_a_reg     <= dev_a_next;
        dev_b_reg     <= dev_b_next;
        dev_src_reg   <= dev_src_next;
        use_spare_reg <= use_spare_next;
        sample_reg    <= sample_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_norm_m : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOGM) |-> m_reg[30])
        else $error("log mantissa not normalized");

    a_iter_start : assert property (@(posedge clk) disable iff (!rst_n)
        iter_req.start |-> !iter_stat.busy)
        else $error("divide/sqrt unit started while busy");

    a_out_load : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && out_valid_reg && out_stall |=> $stable(sample_reg))
        else $error("stalled sample overwritten");

    a_spare_use : assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && spare_valid_reg |=> (state_reg == ST_SCALE))
        else $error("spare deviate not used");

endmodule
